// ===== hw/rtl/aoq_pkg.sv =====
// ----------------------------------------------------------------------------
// Arrival-ordered queue package
// Shared entry type, cell control and status bundles, operation and status
// codes, and field widths for the arrival-ordered process queue.
// ----------------------------------------------------------------------------
`default_nettype none

package aoq_pkg;

    // Field widths of the stream payloads.
    localparam int NAME_W       = 8;
    localparam int ARRIVAL_W    = 16;
    localparam int PRIO_W       = 8;
    localparam int READ_INDEX_W = 4;
    localparam int OPCODE_W     = 2;
    localparam int STATUS_W     = 3;
    localparam int OCC_W        = 5;

    // Default number of queue cells.
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // Operation codes; the unused code behaves as a read.
    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_READ_OK   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 3'd5;

    // One stored process entry.
    typedef struct packed {
        logic [NAME_W-1:0]    name;
        logic [ARRIVAL_W-1:0] arrival;
        logic [PRIO_W-1:0]    prio;
    } entry_t;

    // Per-cell control from the queue controller.
    typedef struct packed {
        logic insert_en;  // an insert beat is being applied this cycle
        logic occupied;   // the cell holds a valid entry
        logic tail;       // the cell is the first free slot
    } cell_ctl_t;

    // Per-cell status back to the queue controller and the next cell.
    typedef struct packed {
        logic ahead;      // the new entry belongs at or ahead of this cell
        logic name_hit;   // the cell holds a valid entry with the probed name
    } cell_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aoq_cell.sv =====
// ----------------------------------------------------------------------------
// Arrival-ordered queue cell
// One slot of the sorted chain. It compares the incoming entry against its
// own, and on an insert either keeps its entry, takes its left neighbor's
// entry (shift toward the tail), or captures the new entry.
// ----------------------------------------------------------------------------
`default_nettype none

module aoq_cell (
    input  wire logic               aclk,
    input  wire aoq_pkg::cell_ctl_t ctl,
    input  wire aoq_pkg::entry_t    key,
    input  wire aoq_pkg::entry_t    left_entry,
    input  wire logic               left_before,
    output aoq_pkg::entry_t         entry,
    output aoq_pkg::cell_stat_t     stat
);

    aoq_pkg::entry_t entry_reg;
    aoq_pkg::entry_t entry_next;
    logic            key_earlier;
    logic            ahead;

    // The new entry goes ahead of this one on an earlier arrival, or on the
    // same arrival with a strictly higher priority.
    assign key_earlier = (key.arrival < entry_reg.arrival) ||
                         ((key.arrival == entry_reg.arrival) &&
                          (key.prio > entry_reg.prio));

    // The first free slot always counts as a place the new entry can land.
    assign ahead = ctl.tail || (ctl.occupied && key_earlier);

    assign stat.ahead    = ahead;
    assign stat.name_hit = ctl.occupied && (key.name == entry_reg.name);
    assign entry         = entry_reg;

    // Shift from the left neighbor if it is also moving, else capture.
    always_comb begin
        entry_next = entry_reg;
        if (ctl.insert_en && ahead) begin
            entry_next = left_before ? left_entry : key;
        end
    end

    // Payload only; the queue count decides which cells are meaningful.
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/arrival_ordered_process_queue.sv =====
// ----------------------------------------------------------------------------
// Arrival-ordered process queue
// Sorted queue of process entries built as a row of compare-and-shift cells,
// with insert, lookup by name and read by position.
// ----------------------------------------------------------------------------
// For every operation (insert, lookup or read), all cells compare the
// incoming beat against their entry in parallel, an insert shifts the later
// entries one cell toward the tail in the cycle the beat is accepted, and
// the result is captured in an output register. The result beat appears in
// the cycle after the input beat is accepted, and a new input beat is
// accepted every cycle as long as the output register is empty or being
// drained, so sustained throughput is one operation per cycle. The cells need
// no clearing after reset; only the entry count and output valid are reset.
// ----------------------------------------------------------------------------
`default_nettype none

module arrival_ordered_process_queue #(
    parameter int QUEUE_DEPTH = aoq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] item_name, [23:8] item_arrival, [31:24] item_priority,
    // [35:32] read_index, [39:36] zero
    input  wire logic [39:0] s_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] entry_name, [23:8] entry_arrival, [31:24] entry_priority,
    // [36:32] occupancy, [39:37] zero
    output logic [39:0]      m_tdata,
    // [2:0] status
    output logic [2:0]       m_tuser
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > aoq_pkg::READ_INDEX_W) ? CNT_W
                                                           : aoq_pkg::READ_INDEX_W;

    // Input beat fields.
    logic [aoq_pkg::OPCODE_W-1:0]     opcode;
    logic [aoq_pkg::READ_INDEX_W-1:0] read_index;
    aoq_pkg::entry_t                  key;
    logic                             s_accept;

    assign opcode       = s_tuser;
    assign key.name     = s_tdata[7:0];
    assign key.arrival  = s_tdata[23:8];
    assign key.prio     = s_tdata[31:24];
    assign read_index   = s_tdata[35:32];

    // Output register state.
    logic                             m_tvalid_reg;
    logic [aoq_pkg::STATUS_W-1:0]     status_reg;
    logic [aoq_pkg::STATUS_W-1:0]     status_next;
    aoq_pkg::entry_t                  rd_entry_reg;
    aoq_pkg::entry_t                  rd_entry_next;
    logic [aoq_pkg::OCC_W-1:0]        occ_reg;
    logic [aoq_pkg::OCC_W-1:0]        occ_next;

    logic [CNT_W-1:0]                 count_reg;
    logic [CNT_W-1:0]                 count_next;
    logic                             full;
    logic                             do_insert;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign do_insert = s_accept && (opcode == aoq_pkg::OP_INSERT) && !full;

    // Cell chain.
    aoq_pkg::cell_ctl_t  ctl   [QUEUE_DEPTH];
    aoq_pkg::cell_stat_t stat  [QUEUE_DEPTH];
    aoq_pkg::entry_t     cells [QUEUE_DEPTH];
    aoq_pkg::entry_t     rd_masked [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] name_hits;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            assign ctl[gi].insert_en = do_insert;
            assign ctl[gi].occupied  = (CNT_W'(gi) < count_reg);
            assign ctl[gi].tail      = (CNT_W'(gi) == count_reg);

            if (gi == 0) begin : g_head
                aoq_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl[gi]),
                    .key         (key),
                    .left_entry  ('0),
                    .left_before (1'b0),
                    .entry       (cells[gi]),
                    .stat        (stat[gi])
                );
            end else begin : g_body
                aoq_cell u_cell (
                    .aclk        (aclk),
                    .ctl         (ctl[gi]),
                    .key         (key),
                    .left_entry  (cells[gi-1]),
                    .left_before (stat[gi-1].ahead),
                    .entry       (cells[gi]),
                    .stat        (stat[gi])
                );
            end

            assign name_hits[gi] = stat[gi].name_hit;

            // Read select: only the cell at the requested position passes.
            assign rd_masked[gi] = (CMP_W'(gi) == CMP_W'(read_index)) ? cells[gi]
                                                                      : '0;
        end
    endgenerate

    // Result and next count for the accepted beat.
    always_comb begin
        aoq_pkg::entry_t rd_sel;
        rd_sel        = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            rd_sel = rd_sel | rd_masked[i];
        end

        count_next    = count_reg;
        status_next   = aoq_pkg::ST_BAD_INDEX;
        rd_entry_next = '0;
        case (opcode)
            aoq_pkg::OP_INSERT: begin
                if (full) begin
                    status_next = aoq_pkg::ST_FULL;
                end else begin
                    status_next = aoq_pkg::ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            aoq_pkg::OP_LOOKUP: begin
                status_next = (|name_hits) ? aoq_pkg::ST_FOUND : aoq_pkg::ST_NOT_FOUND;
            end
            default: begin
                if (CMP_W'(read_index) < CMP_W'(count_reg)) begin
                    status_next   = aoq_pkg::ST_READ_OK;
                    rd_entry_next = rd_sel;
                end
            end
        endcase
        occ_next = aoq_pkg::OCC_W'(count_next);
    end

    // Count and output valid are control state; the result payload is not reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            status_reg   <= status_next;
            rd_entry_reg <= rd_entry_next;
            occ_reg      <= occ_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {3'b000, occ_reg, rd_entry_reg.prio,
                       rd_entry_reg.arrival, rd_entry_reg.name};

    // The count never passes the number of cells.
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count exceeds queue depth");

    // An insert into a queue with room grows the count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        do_insert |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not advance the entry count");

    // An insert into a full queue is dropped and reported as such.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (opcode == aoq_pkg::OP_INSERT) && full) |=>
            ((m_tuser == aoq_pkg::ST_FULL) && $stable(count_reg)))
        else $error("insert into full queue was not dropped");

    // A lookup, an insert or a failed read never returns entry fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != aoq_pkg::ST_READ_OK)) |-> (m_tdata[31:0] == '0))
        else $error("entry fields set on a non-read result");

endmodule

`default_nettype wire
